### design/assert_macros.svh
// Assertion macros shared by the stable priority queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/spq_pkg.sv
// Package for the stable priority queue: field widths, status codes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int NUM_LEVELS_DEF = 5;

    localparam int VALUE_W  = 16;
    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller to datapath.
    typedef struct packed {
        logic load;          // capture the input beat
        logic issue;         // read the memories at the working slot
        logic push_commit;   // link the new entry into its level list
        logic pop_commit;    // unlink the head entry and free its slot
        logic reject_full;   // report a refused push
        logic reject_empty;  // report a pop on an empty queue
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
    } t_stat;

endpackage

`default_nettype wire

### design/spq_ctrl.sv
// Controller state machine of the stable priority queue.
// Depends on spq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_stat.is_pop && i_stat.empty) begin
                    o_cmd.reject_empty = 1'b1;
                    n_state            = S_IDLE;
                end else if (!i_stat.is_pop && i_stat.full) begin
                    o_cmd.reject_full = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.push_commit = !i_stat.is_pop;
                o_cmd.pop_commit  = i_stat.is_pop;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    // At most one result-producing action per cycle.
    `SPQ_ASSERT(a_one_action, i_clk, i_rst_n, $onehot0({o_cmd.push_commit, o_cmd.pop_commit, o_cmd.reject_full, o_cmd.reject_empty}), "spq_ctrl: more than one action in a cycle")
    // A commit always follows an issue cycle that did not reject.
    `SPQ_ASSERT(a_commit_after_issue, i_clk, i_rst_n, (o_cmd.push_commit || o_cmd.pop_commit) |-> $past(o_cmd.issue) && !$past(o_cmd.reject_full) && !$past(o_cmd.reject_empty), "spq_ctrl: commit without a clean issue")

endmodule

`default_nettype wire

### design/spq_datapath.sv
// Datapath of the stable priority queue: slot memories, per-level linked
// lists, free list and result register. Depends on spq_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic                i_action,
    input  wire logic [VALUE_W-1:0]  i_value,
    input  wire logic [LEVEL_W-1:0]  i_level,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [VALUE_W-1:0]       o_popped_value,
    output logic [LEVEL_W-1:0]       o_popped_level,
    output logic [OCC_W-1:0]         o_occupancy
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LIW = $clog2(NUM_LEVELS);

    // Slot memories: data word and link to the next slot of the same list.
    logic [VALUE_W-1:0] mem_val  [CAPACITY];
    logic [AW-1:0]      mem_next [CAPACITY];

    // One linked list per level.
    logic [AW-1:0]         r_head [NUM_LEVELS];
    logic [AW-1:0]         r_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] r_nonempty;

    logic [CW-1:0] r_count;
    // Slots at or above r_fill were never handed out; freed slots below it
    // form a stack linked through mem_next.
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_free_head;

    logic               r_action;
    logic [VALUE_W-1:0] r_value;
    logic [LEVEL_W-1:0] r_lvl;
    logic [LIW-1:0]     r_sel;
    logic [AW-1:0]      r_slot;
    logic [VALUE_W-1:0] r_rd_val;
    logic [AW-1:0]      r_rd_next;

    logic                r_valid;
    t_status             r_status;
    logic [VALUE_W-1:0]  r_pval;
    logic [LEVEL_W-1:0]  r_plvl;

    logic [LEVEL_W-1:0] lv_clamp;
    logic [LIW-1:0]     hi_idx;
    logic [LIW-1:0]     n_sel;
    logic [LEVEL_W-1:0] n_lvl;
    logic               free_avail;
    logic [AW-1:0]      rd_addr;
    logic               next_we;
    logic [AW-1:0]      next_waddr;
    logic [AW-1:0]      next_wdata;

    always_comb begin
        lv_clamp = i_level;
        if (i_level == '0) begin
            lv_clamp = LEVEL_W'(1);
        end else if (int'(i_level) > NUM_LEVELS) begin
            lv_clamp = LEVEL_W'(NUM_LEVELS);
        end
    end

    // Highest non-empty level wins; later iterations override earlier ones.
    always_comb begin
        hi_idx = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (r_nonempty[i]) begin
                hi_idx = LIW'(i);
            end
        end
    end

    assign n_sel = i_action ? hi_idx : LIW'(lv_clamp - LEVEL_W'(1));
    assign n_lvl = LEVEL_W'(int'(hi_idx) + 1);

    assign free_avail = (r_fill != r_count);
    assign rd_addr    = r_action   ? r_head[r_sel] :
                        free_avail ? r_free_head   : r_fill[AW-1:0];

    assign next_we    = i_cmd.pop_commit || (i_cmd.push_commit && r_nonempty[r_sel]);
    assign next_waddr = i_cmd.pop_commit ? r_slot      : r_tail[r_sel];
    assign next_wdata = i_cmd.pop_commit ? r_free_head : r_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_val  <= mem_val[rd_addr];
            r_rd_next <= mem_next[rd_addr];
        end
        if (i_cmd.push_commit) begin
            mem_val[r_slot] <= r_value;
        end
        if (next_we) begin
            mem_next[next_waddr] <= next_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_value  <= i_value;
            r_lvl    <= n_lvl;
            r_sel    <= n_sel;
        end
        if (i_cmd.issue) begin
            r_slot <= rd_addr;
        end
        if (i_cmd.push_commit) begin
            r_tail[r_sel] <= r_slot;
            if (!r_nonempty[r_sel]) begin
                r_head[r_sel] <= r_slot;
            end
            if (free_avail) begin
                r_free_head <= r_rd_next;
            end
        end
        if (i_cmd.pop_commit) begin
            r_head[r_sel] <= r_rd_next;
            r_free_head   <= r_slot;
        end
        if (i_cmd.pop_commit) begin
            r_status <= ST_OK;
            r_pval   <= r_rd_val;
            r_plvl   <= r_lvl;
        end else if (i_cmd.push_commit) begin
            r_status <= ST_OK;
            r_pval   <= '0;
            r_plvl   <= '0;
        end else if (i_cmd.reject_full) begin
            r_status <= ST_FULL;
            r_pval   <= '0;
            r_plvl   <= '0;
        end else if (i_cmd.reject_empty) begin
            r_status <= ST_EMPTY;
            r_pval   <= '0;
            r_plvl   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_fill     <= '0;
            r_nonempty <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.push_commit || i_cmd.pop_commit ||
                       i_cmd.reject_full || i_cmd.reject_empty;
            if (i_cmd.push_commit) begin
                r_count           <= r_count + CW'(1);
                r_nonempty[r_sel] <= 1'b1;
                if (!free_avail) begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (i_cmd.pop_commit) begin
                r_count <= r_count - CW'(1);
                // The list empties when its head is also its tail.
                if (r_slot == r_tail[r_sel]) begin
                    r_nonempty[r_sel] <= 1'b0;
                end
            end
        end
    end

    assign o_stat.is_pop = r_action;
    assign o_stat.full   = (r_count == CW'(CAPACITY));
    assign o_stat.empty  = (r_count == '0);

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_pval;
    assign o_popped_level = r_plvl;
    assign o_occupancy    = OCC_W'(r_count);

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= CW'(CAPACITY)) && (r_count <= r_fill) && (r_fill <= CW'(CAPACITY)), "spq_datapath: count or fill out of range")
    `SPQ_ASSERT(a_push_count, i_clk, i_rst_n, i_cmd.push_commit |=> r_count == $past(r_count) + CW'(1), "spq_datapath: push did not grow the queue")
    `SPQ_ASSERT_ALWAYS(a_empty_lists, i_clk, (i_rst_n && (r_count == '0)) |-> (r_nonempty == '0), "spq_datapath: empty queue with a live level list")

endmodule

`default_nettype wire

### design/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Usage:
//   Raise start with i_action, i_value and i_level while busy is low; the
//   beat is taken at that rising edge. A push (action 0) stores the value
//   behind every entry of equal or higher level; a pop (action 1) removes
//   the oldest entry of the highest level.
//   Each beat yields exactly one result, shown for one cycle with o_valid:
//   o_status, o_popped_value, o_popped_level and o_occupancy.
//   A push or pop that succeds registers its result in the commit state,
//   after the issue state; a refused push or a pop on an empty queue
//   registers it in the issue state. o_valid is high in the cycle after.
//   The next beat can be taken at the edge ending that cycle, so a new
//   beat is never taken before the last one has given its result.
//   The three steps are accept, one registered read of the slot memories,
//   and the write back of links, pointers and counts.
//   Reset (synchronous, active low) empties the queue at once; slot
//   contents are left as they are and no clearing pass runs.
//   The receiver cannot stall: each result must be taken when shown.
`default_nettype none

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_action,
    input  wire logic [VALUE_W-1:0]  i_value,
    input  wire logic [LEVEL_W-1:0]  i_level,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [VALUE_W-1:0]       o_popped_value,
    output logic [LEVEL_W-1:0]       o_popped_level,
    output logic [OCC_W-1:0]         o_occupancy
);

    t_cmd  cmd;
    t_stat stat;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    spq_datapath #(
        .CAPACITY   (CAPACITY),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_level        (i_level),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_popped_level (o_popped_level),
        .o_occupancy    (o_occupancy)
    );

endmodule

`default_nettype wire

### test/stable_priority_queue_tb.sv
// Self-checking testbench for stable_priority_queue: random push and pop beats
// checked against a sorted-array predictor of the queue. Depends on spq_pkg.
`timescale 1ns / 1ps

module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int LEVELS     = NUM_LEVELS_DEF;
    localparam int RAND_BEATS = 1350;
    localparam int IDLE_LIMIT = 2000;
    localparam bit ACT_PUSH   = 1'b0;
    localparam bit ACT_POP    = 1'b1;

    typedef struct {
        bit                 action;
        bit [VALUE_W-1:0]   value;
        bit [LEVEL_W-1:0]   level;
        int unsigned        gap_pct;
        bit                 drain;
    } beat_t;

    typedef struct {
        t_status            status;
        bit [VALUE_W-1:0]   value;
        bit [LEVEL_W-1:0]   level;
        bit [OCC_W-1:0]     occ;
    } queue_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic i_action = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic [LEVEL_W-1:0] i_level = '0;
    logic busy;
    logic o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [VALUE_W-1:0]  o_popped_value;
    logic [LEVEL_W-1:0]  o_popped_level;
    logic [OCC_W-1:0]    o_occupancy;

    beat_t          pending_beats[$];
    queue_result_t  expected_results[$];

    // Predictor state: entries kept sorted, head at index 0.
    bit [VALUE_W-1:0] sorted_value[CAP];
    bit [LEVEL_W-1:0] sorted_level[CAP];
    int               held_count = 0;

    int  mismatch_count = 0;
    int  gen_count = 0;
    int  idle_cycles = 0;
    bit  beat_taken = 1'b0;
    bit  next_start;
    beat_t head_beat;
    queue_result_t got_result;
    queue_result_t want_result;

    stable_priority_queue u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_level        (i_level),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_popped_level (o_popped_level),
        .o_occupancy    (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic queue_result_t queue_model_step(beat_t b);
        queue_result_t r;
        bit [LEVEL_W-1:0] lv;
        int pos;
        r.status = ST_OK;
        r.value  = '0;
        r.level  = '0;
        if (b.action == ACT_PUSH) begin
            if (held_count >= CAP) begin
                r.status = ST_FULL;
            end else begin
                lv = b.level;
                if (lv < 1) lv = LEVEL_W'(1);
                if (lv > LEVELS) lv = LEVEL_W'(LEVELS);
                pos = 0;
                while (pos < held_count && sorted_level[pos] >= lv) pos++;
                for (int i = held_count; i > pos; i--) begin
                    sorted_value[i] = sorted_value[i-1];
                    sorted_level[i] = sorted_level[i-1];
                end
                sorted_value[pos] = b.value;
                sorted_level[pos] = lv;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.value = sorted_value[0];
                r.level = sorted_level[0];
                for (int i = 1; i < held_count; i++) begin
                    sorted_value[i-1] = sorted_value[i];
                    sorted_level[i-1] = sorted_level[i];
                end
                held_count--;
            end
        end
        r.occ = held_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %0s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Queues one beat and tracks the expected fill level in gen_count.
    task automatic add_beat(bit act, bit [VALUE_W-1:0] val, bit [LEVEL_W-1:0] lvl,
                            int unsigned pct, bit drain);
        beat_t b;
        b.action  = act;
        b.value   = val;
        b.level   = lvl;
        b.gap_pct = pct;
        b.drain   = drain;
        pending_beats.push_back(b);
        if (act == ACT_PUSH && gen_count < CAP) gen_count++;
        if (act == ACT_POP && gen_count > 0) gen_count--;
    endtask

    // Driver: presents the next beat at the falling edge, holding it until taken.
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !beat_taken)) begin
            next_start = 1'b0;
            if (pending_beats.size() > 0) begin
                head_beat = pending_beats[0];
                if (!(head_beat.drain && expected_results.size() != 0) &&
                    $urandom_range(99) >= head_beat.gap_pct) begin
                    void'(pending_beats.pop_front());
                    i_action   <= head_beat.action;
                    i_value    <= head_beat.value;
                    i_level    <= head_beat.level;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Monitor: checks results, then predicts the beat taken at this edge.
    always @(posedge i_clk) begin
        beat_taken = i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_occupancy, 0);
            end else begin
                want_result = expected_results.pop_front();
                got_result.status = t_status'(o_status);
                got_result.value  = o_popped_value;
                got_result.level  = o_popped_level;
                got_result.occ    = o_occupancy;
                if (got_result.status !== want_result.status)
                    report_mismatch("status", o_status, want_result.status);
                if (got_result.value !== want_result.value)
                    report_mismatch("popped_value", o_popped_value, want_result.value);
                if (got_result.level !== want_result.level)
                    report_mismatch("popped_level", o_popped_level, want_result.level);
                if (got_result.occ !== want_result.occ)
                    report_mismatch("occupancy", o_occupancy, want_result.occ);
            end
        end
        if (beat_taken) begin
            head_beat.action = i_action;
            head_beat.value  = i_value;
            head_beat.level  = i_level;
            expected_results.push_back(queue_model_step(head_beat));
        end
    end

    // Watchdog on cycles in which no beat and no result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] timeout: nothing moved for %0d cycles", $time, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int run_len;
        int push_pct;
        int unsigned pct;
        bit act;
        bit [LEVEL_W-1:0] lvl;

        // Directed part: pop on empty, every level including the saturating
        // codes zero, six and seven, extreme data words, then drain to empty.
        add_beat(ACT_POP, 16'hFFFF, 3'd7, 29, 1'b0);
        add_beat(ACT_PUSH, 16'h0000, 3'd0, 29, 1'b0);
        add_beat(ACT_PUSH, 16'hFFFF, 3'd1, 29, 1'b0);
        add_beat(ACT_PUSH, 16'h1234, 3'd7, 29, 1'b0);
        add_beat(ACT_PUSH, 16'h5A5A, 3'd6, 29, 1'b0);
        add_beat(ACT_PUSH, 16'hA5A5, 3'd5, 29, 1'b0);
        add_beat(ACT_PUSH, 16'h0F0F, 3'd3, 29, 1'b0);
        add_beat(ACT_PUSH, 16'hF0F0, 3'd2, 29, 1'b0);
        add_beat(ACT_PUSH, 16'h8001, 3'd4, 29, 1'b0);
        for (int i = 0; i < 9; i++) add_beat(ACT_POP, 16'h0000, 3'd0, 29, 1'b0);

        // Random part: runs that lean toward pushing or popping, or are balanced, so the queue
        // swings between empty and full and both boundaries get exercised.
        n = 0;
        while (n < RAND_BEATS) begin
            run_len = $urandom_range(60, 8);
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            for (int k = 0; k < run_len && n < RAND_BEATS; k++) begin
                pct = (n < 450) ? 29 : (n < 900) ? 58 : 0;
                act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
                if ($urandom_range(9) == 0)
                    lvl = LEVEL_W'($urandom_range(7));
                else
                    lvl = LEVEL_W'($urandom_range(LEVELS, 1));
                add_beat(act, VALUE_W'($urandom), lvl, pct, (n == 450 || n == 900));
                n++;
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        while (expected_results.size() != 0) begin
            report_mismatch("missing result", 0, expected_results[0].occ);
            void'(expected_results.pop_front());
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/stable_priority_queue.sv
test/stable_priority_queue_tb.sv
